/* rtl/mfb_pkg.sv */
// shared types and constants for the monochrome frame buffer drawer
// no dependencies
package mfb_pkg;

	// command codes
	localparam logic [2:0] FUNC_SET_PIXEL = 3'd0;
	localparam logic [2:0] FUNC_CLR_PIXEL = 3'd1;
	localparam logic [2:0] FUNC_LINE      = 3'd2;
	localparam logic [2:0] FUNC_CIRCLE    = 3'd3;
	localparam logic [2:0] FUNC_CLR_ALL   = 3'd4;
	localparam logic [2:0] FUNC_READ      = 3'd5;

	// slope is scaled by this before the divide
	localparam int SLOPE_SCALE = 10;

	// x/10 as (x*1639)>>14, exact for every x below 2048
	localparam int SLOPE_RECIP    = 1639;
	localparam int SLOPE_RECIP_SH = 14;

	// dividend width of the slope divider: (rows-1)*10 stays below 2048
	localparam int DIV_W = 11;

	// signed pixel coordinate, wide enough for centre +/- radius
	localparam int COORD_W = 11;
	typedef logic signed [COORD_W-1:0] coord_t;

endpackage

/* rtl/mfb_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/mfb_div.sv */
// restoring divider, one quotient bit per cycle
// uses mfb_pkg for the dividend width
module mfb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mfb_pkg::DIV_W-1:0] dividend,
	input  logic [7:0]                divisor,
	output logic                      done,
	output logic [mfb_pkg::DIV_W-1:0] quotient
);
	import mfb_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [7:0]       dvs_q;
	logic [7:0]       rem_q;
	logic [8:0]       trial;
	logic [8:0]       diff;
	logic             qbit;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[7:0] : trial[7:0];
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

/* rtl/mono_framebuffer_line_circle_drawer_unit.sv */
// top level: command sequencer, pixel read-modify-write and read-back port
// uses mfb_pkg, mfb_ram (frame store) and mfb_div (slope divider)
//
//  channel | handshake        | fields
//  --------+------------------+-----------------------------------------
//  in      | in_valid/in_stall| func, x_a, y_a, x_b, y_b, radius
//  out     | out_valid/out_stall | read_data
//
// after reset the store is cleared one byte a cycle, and clear screen does
// the same; no item is taken meanwhile; set/clear pixel: on screen, a read
// then a write; read byte: a hold state, then output, held while the
// output stalls; sloped or horizontal line: slope divide (an 11-step
// divider pass, then a split into tens and units), then the pixels;
// vertical lines skip the divide; circle step: a test, 8 mirrored points,
// an update; each pixel on screen is a read, then a write, of its byte
module mono_framebuffer_line_circle_drawer_unit #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [7:0] x_a,
	input  logic [7:0] y_a,
	input  logic [7:0] x_b,
	input  logic [7:0] y_b,
	input  logic [7:0] radius,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);
	import mfb_pkg::*;

	localparam int ROWS  = PAGES * 8;
	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_CLEAR   = 12'b000000000010,
		S_RD_OUT  = 12'b000000000100,
		S_DIV1    = 12'b000000001000,
		S_DIV2    = 12'b000000010000,
		S_LINE_PT = 12'b000000100000,
		S_CIR_TST = 12'b000001000000,
		S_CIR_PT  = 12'b000010000000,
		S_PT_RD   = 12'b000100000000,
		S_PT_WR   = 12'b001000000000,
		S_CIR_UPD = 12'b010000000000,
		S_HOLD    = 12'b100000000000
	} state_t;

	typedef enum logic [1:0] {
		OP_PIX  = 2'd0,
		OP_LINE = 2'd1,
		OP_CIRC = 2'd2
	} op_t;

	state_t state_q, state_d;

	logic           accept;
	logic [AW-1:0]  clr_q;
	op_t            op_q;
	logic           on_q;
	coord_t         px_q, py_q;
	logic [AW-1:0]  wa_q;
	logic [2:0]     bit_q;
	logic           rd_ok_q;
	logic           out_valid_q;
	logic [7:0]     read_data_q;

	// line registers
	logic [7:0] lx1_q, ly1_q, n_q, i_q, slq_q, offq_q;
	logic [3:0] slr_q, offr_q;
	logic       vert_q;

	// circle registers
	logic [7:0]  cx_q, cy_q, a_q, c_q;
	logic [2:0]  k_q;
	logic [15:0] aa_q, cc_q, rr_q;

	// ram port
	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	// divider port
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dvd, div_q;
	logic [7:0]       div_dvs;

	// slope split into tens and units
	logic [21:0] sl_prod;
	logic [7:0]  sl_quo;
	logic [3:0]  sl_rem;

	// command decode
	logic [7:0]  dx_in, dy_in;
	logic        line_ok, line_vert;
	logic        rd_in_range;
	logic [15:0] rd_addr16;
	logic [15:0] r_sq;

	// point stage
	logic        pt_on_screen;
	logic [15:0] pt_addr16;
	logic        pt_done;
	logic [7:0]  pt_mask;

	// circle update
	logic [7:0]  a_inc;
	logic [15:0] aa_inc;
	logic [17:0] cir_sum;
	logic        cir_step_c;
	logic [16:0] cc_twice;

	// line step
	logic [4:0]  off_sum;
	logic        off_carry;

	// circle point select
	coord_t cx_s, cy_s, a_s, c_s, cpx, cpy;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = state_q != S_IDLE;

	assign dx_in = x_b - x_a;
	assign dy_in = y_b - y_a;
	assign line_ok = ({1'b0, x_b} <= 9'(COLUMNS - 1)) && ({1'b0, y_b} <= 9'(ROWS - 1))
		&& (x_a <= x_b) && (y_a <= y_b) && ((dx_in != 8'd0) || (dy_in != 8'd0));
	assign line_vert   = dx_in == 8'd0;
	assign rd_in_range = ({1'b0, x_a} < 9'(COLUMNS)) && ({1'b0, y_a} < 9'(PAGES));
	assign rd_addr16   = 16'(x_a) * 16'(PAGES) + 16'(y_a);
	assign r_sq        = 16'(radius) * 16'(radius);

	assign sl_prod = 22'(div_q) * 22'(SLOPE_RECIP);
	assign sl_quo  = sl_prod[SLOPE_RECIP_SH +: 8];
	assign sl_rem  = 4'(div_q - DIV_W'({sl_quo, 3'b000}) - DIV_W'({sl_quo, 1'b0}));

	assign pt_on_screen = (px_q >= 0) && (py_q >= 0) && (px_q < COORD_W'(COLUMNS))
		&& (py_q < COORD_W'(ROWS));
	assign pt_addr16 = 16'(px_q[7:0]) * 16'(PAGES) + 16'(py_q[6:3]);
	assign pt_mask   = 8'(1) << bit_q;
	assign pt_done   = ((state_q == S_PT_RD) && !pt_on_screen) || (state_q == S_PT_WR);

	assign a_inc      = a_q + 8'd1;
	assign aa_inc     = aa_q + 16'({a_q, 1'b1});
	assign cir_sum    = 18'(aa_inc) + 18'(cc_q);
	assign cir_step_c = cir_sum > 18'(rr_q);
	assign cc_twice   = {cc_q, 1'b0};

	assign off_sum   = 5'(offr_q) + 5'(slr_q);
	assign off_carry = off_sum >= 5'(SLOPE_SCALE);

	assign cx_s = coord_t'({3'b000, cx_q});
	assign cy_s = coord_t'({3'b000, cy_q});
	assign a_s  = coord_t'({3'b000, a_q});
	assign c_s  = coord_t'({3'b000, c_q});

	// eight-way mirrored points of the current octant step
	always_comb begin
		cpx = cx_s;
		cpy = cy_s;
		case (k_q)
			3'd0: begin cpx = cx_s + a_s; cpy = cy_s - c_s; end
			3'd1: begin cpx = cx_s - a_s; cpy = cy_s - c_s; end
			3'd2: begin cpx = cx_s - a_s; cpy = cy_s + c_s; end
			3'd3: begin cpx = cx_s + a_s; cpy = cy_s + c_s; end
			3'd4: begin cpx = cx_s + c_s; cpy = cy_s + a_s; end
			3'd5: begin cpx = cx_s + c_s; cpy = cy_s - a_s; end
			3'd6: begin cpx = cx_s - c_s; cpy = cy_s - a_s; end
			3'd7: begin cpx = cx_s - c_s; cpy = cy_s + a_s; end
			default: begin cpx = cx_s; cpy = cy_s; end
		endcase
	end

	// divider operands: dy*10/dx
	always_comb begin
		div_start = 1'b0;
		div_dvd   = DIV_W'({dy_in, 3'b000}) + DIV_W'({dy_in, 1'b0});
		div_dvs   = dx_in;
		if (accept && (func == FUNC_LINE) && line_ok && !line_vert) begin
			div_start = 1'b1;
		end
	end

	// frame store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = on_q ? (ram_rdata | pt_mask) : (ram_rdata & ~pt_mask);
		ram_re    = 1'b0;
		ram_raddr = pt_addr16[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'h00;
			end
			S_PT_RD: begin
				ram_re = pt_on_screen;
			end
			S_PT_WR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_re    = accept && (func == FUNC_READ) && rd_in_range;
				ram_raddr = rd_addr16[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_SET_PIXEL, FUNC_CLR_PIXEL: state_d = S_PT_RD;
						FUNC_LINE: begin
							if (!line_ok) begin
								state_d = S_IDLE;
							end else if (line_vert) begin
								state_d = S_LINE_PT;
							end else begin
								state_d = S_DIV1;
							end
						end
						FUNC_CIRCLE:  state_d = (radius == 8'd0) ? S_PT_RD : S_CIR_TST;
						FUNC_CLR_ALL: state_d = S_CLEAR;
						FUNC_READ:    state_d = S_HOLD;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR:  if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
			S_HOLD:   state_d = S_RD_OUT;
			S_RD_OUT: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			S_DIV1:   if (div_done) state_d = S_DIV2;
			S_DIV2:   state_d = S_LINE_PT;
			S_LINE_PT: state_d = (i_q == n_q) ? S_IDLE : S_PT_RD;
			S_CIR_TST: state_d = (17'(rr_q) <= cc_twice) ? S_CIR_PT : S_IDLE;
			S_CIR_PT:  state_d = S_PT_RD;
			S_CIR_UPD: state_d = S_CIR_TST;
			S_PT_RD, S_PT_WR: begin
				if (state_q == S_PT_RD && pt_on_screen) begin
					state_d = S_PT_WR;
				end else begin
					case (op_q)
						OP_LINE: state_d = S_LINE_PT;
						OP_CIRC: state_d = (k_q == 3'd7) ? S_CIR_UPD : S_CIR_PT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if ((state_q == S_RD_OUT) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			on_q    <= func != FUNC_CLR_PIXEL;
			px_q    <= coord_t'({3'b000, x_a});
			py_q    <= coord_t'({3'b000, y_a});
			rd_ok_q <= rd_in_range;
			lx1_q   <= x_a;
			ly1_q   <= y_a;
			vert_q  <= line_vert;
			n_q     <= line_vert ? dy_in : dx_in;
			i_q     <= 8'd0;
			offq_q  <= 8'd0;
			offr_q  <= 4'd0;
			slq_q   <= 8'd0;
			slr_q   <= 4'd0;
			cx_q    <= x_a;
			cy_q    <= y_a;
			a_q     <= 8'd0;
			c_q     <= radius;
			aa_q    <= 16'd0;
			cc_q    <= r_sq;
			rr_q    <= r_sq;
			k_q     <= 3'd0;
			case (func)
				FUNC_LINE:   op_q <= OP_LINE;
				FUNC_CIRCLE: op_q <= (radius == 8'd0) ? OP_PIX : OP_CIRC;
				default:     op_q <= OP_PIX;
			endcase
		end
		if (state_q == S_DIV2) begin
			slq_q <= sl_quo;
			slr_q <= sl_rem;
		end
		if (state_q == S_LINE_PT) begin
			px_q <= coord_t'({3'b000, lx1_q}) + (vert_q ? coord_t'(0) : coord_t'({3'b000, i_q}));
			py_q <= coord_t'({3'b000, ly1_q})
				+ coord_t'({3'b000, (vert_q ? i_q : offq_q)});
		end
		if (state_q == S_CIR_TST) begin
			k_q <= 3'd0;
		end
		if (state_q == S_CIR_PT) begin
			px_q <= cpx;
			py_q <= cpy;
		end
		if ((state_q == S_PT_RD) && pt_on_screen) begin
			wa_q  <= pt_addr16[AW-1:0];
			bit_q <= py_q[2:0];
		end
		if (pt_done && (op_q == OP_LINE)) begin
			i_q    <= i_q + 8'd1;
			offr_q <= off_carry ? 4'(off_sum - 5'(SLOPE_SCALE)) : off_sum[3:0];
			offq_q <= offq_q + slq_q + 8'(off_carry);
		end
		if (pt_done && (op_q == OP_CIRC)) begin
			k_q <= k_q + 3'd1;
		end
		if (state_q == S_CIR_UPD) begin
			// step a; if outside the circle, step c in and keep a
			if (cir_step_c) begin
				c_q  <= c_q - 8'd1;
				cc_q <= cc_q - 16'({c_q, 1'b0}) + 16'd1;
			end else begin
				a_q  <= a_inc;
				aa_q <= aa_inc;
			end
		end
		if ((state_q == S_RD_OUT) && (!out_valid_q || !out_stall)) begin
			read_data_q <= rd_ok_q ? ram_rdata : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	mfb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mfb_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_q)
	);
endmodule
